// ----- sv/ppm_pkg.sv -----
// Shared types and constants for the P6 stream parser.
// Holds the result kinds, the item and result records and the header byte tables.
// No dependencies.
package ppm_pkg;

  // Largest accepted image dimensions
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int ACC_W   = 17;

  // Characters that appear in the header
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_P     = 8'h50;
  localparam logic [7:0] CHR_SIX   = 8'h36;
  localparam logic [7:0] CHR_TWO   = 8'h32;
  localparam logic [7:0] CHR_FIVE  = 8'h35;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PIXEL      = 3'd0,
    KIND_HEADER     = 3'd1,
    KIND_BAD_MAGIC  = 3'd2,
    KIND_BAD_DIM    = 3'd3,
    KIND_BAD_MAXVAL = 3'd4,
    KIND_TRUNC      = 3'd5
  } kind_e;

  // One input request
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } item_t;

  // One result request
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [1:0]         missing;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
    logic               last;
  } result_t;

  // Expected bytes of the magic line "P6\n"
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = CHR_P;
      2'd1:    b = CHR_SIX;
      default: b = CHR_NL;
    endcase
    return b;
  endfunction

  // Expected bytes of the maxval line "255\n"
  function automatic logic [7:0] maxval_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = CHR_TWO;
      2'd1:    b = CHR_FIVE;
      2'd2:    b = CHR_FIVE;
      default: b = CHR_NL;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/ppm_in_stage.sv -----
// Input register of the P6 stream parser.
// Holds one incoming byte request until the parse stage takes it; uses ppm_pkg.
module ppm_in_stage
  import ppm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  held_valid_o,
  output item_t held_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held request is not being taken
  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_o       = item_q;

endmodule

// ----- sv/ppm_parse.sv -----
// Parse stage of the P6 stream parser: header state machine and pixel grouping.
// Updates the parse state for one byte per fire and builds its result; uses ppm_pkg.
module ppm_parse
  import ppm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  // Parse phases
  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         pos_q, pos_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [1:0]         chan_q, chan_d;
  logic [7:0]         red_q, red_d;
  logic [7:0]         green_q, green_d;

  logic [7:0]       b;
  logic             eos;
  logic             is_digit;
  logic [DIM_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [ACC_W-1:0] limit;
  logic             digit_ok;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;

  assign b   = item_i.data;
  assign eos = item_i.eos;

  // Decimal accumulate: acc * 10 + digit, checked against the dimension limit
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign acc      = (phase_q == PH_WIDTH) ? width_q : height_q;
  assign limit    = (phase_q == PH_WIDTH) ? ACC_W'(MAX_WIDTH) : ACC_W'(MAX_HEIGHT);
  assign acc_next = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(ACC_W-4){1'b0}}, b[3:0]};
  assign digit_ok = is_digit && (acc_next <= limit);

  // Raster position compares
  assign col_inc = {1'b0, col_q} + DIM_W'(1);
  assign row_inc = {1'b0, row_q} + DIM_W'(1);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    chan_d      = chan_q;
    red_d       = red_q;
    green_d     = green_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PH_MAGIC: begin
        if (eos || (b != magic_byte(pos_q))) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_MAGIC;
          phase_d     = PH_HALT;
        end else if (pos_q == 2'd2) begin
          pos_d   = 2'd0;
          phase_d = PH_WIDTH;
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (eos) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_DIM;
          phase_d     = PH_HALT;
        end else if ((phase_q == PH_WIDTH) && (b == CHR_SPACE)) begin
          phase_d = PH_HEIGHT;
        end else if ((phase_q == PH_HEIGHT) && (b == CHR_NL)) begin
          phase_d = PH_MAXVAL;
          pos_d   = 2'd0;
        end else if (!digit_ok) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_DIM;
          phase_d     = PH_HALT;
        end else if (phase_q == PH_WIDTH) begin
          width_d = acc_next[DIM_W-1:0];
        end else begin
          height_d = acc_next[DIM_W-1:0];
        end
      end
      PH_MAXVAL: begin
        if (eos || (b != maxval_byte(pos_q))) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_MAXVAL;
          phase_d     = PH_HALT;
        end else if (pos_q == 2'd3) begin
          pos_d       = 2'd0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_HEADER;
          res_o.img_w = width_q;
          res_o.img_h = height_q;
          if ((width_q == '0) || (height_q == '0)) begin
            res_o.last = 1'b1;
            phase_d    = PH_HALT;
          end else begin
            phase_d = PH_PIXELS;
          end
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      PH_PIXELS: begin
        if (eos) begin
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_TRUNC;
          res_o.column  = col_q;
          res_o.row     = row_q;
          res_o.missing = chan_q;
          phase_d       = PH_HALT;
        end else if (chan_q == 2'd0) begin
          red_d  = b;
          chan_d = 2'd1;
        end else if (chan_q == 2'd1) begin
          green_d = b;
          chan_d  = 2'd2;
        end else begin
          chan_d       = 2'd0;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_PIXEL;
          res_o.red    = red_q;
          res_o.green  = green_q;
          res_o.blue   = b;
          res_o.column = col_q;
          res_o.row    = row_q;
          if (col_inc >= width_q) begin
            col_d = '0;
            if (row_inc >= height_q) begin
              res_o.last = 1'b1;
              phase_d    = PH_HALT;
            end else begin
              row_d = row_inc[COORD_W-1:0];
            end
          end else begin
            col_d = col_inc[COORD_W-1:0];
          end
        end
      end
      default: begin
        // Halted or finished: ignore everything
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      pos_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      chan_q   <= '0;
      red_q    <= '0;
      green_q  <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      chan_q   <= chan_d;
      red_q    <= red_d;
      green_q  <= green_d;
    end
  end

endmodule

// ----- sv/ppm_out_stage.sv -----
// Result register of the P6 stream parser.
// Holds one result request until the sink takes it; uses ppm_pkg.
module ppm_out_stage
  import ppm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free now, or emptied at this edge
  assign room_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/ppm_p6_stream_parser.sv -----
// Top level of the binary PPM (P6) stream parser.
// Instantiates the input register, parse stage and result register; uses ppm_pkg.
//
// Takes one stream byte per cycle while the input is not stalled and reports the
// header, each pixel with its column and row, or the first error; after an error,
// the last pixel or a header with a zero dimension the block ignores input until
// reset. A byte waits in the input register until the result register has room;
// its result, if any, is then loaded into the result register. Input stalls only
// while the result register holds an unclaimed result and a byte is already waiting.
module ppm_p6_stream_parser
  import ppm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_stream_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          result_kind_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [COORD_W-1:0]  column_o,
  output logic [COORD_W-1:0]  row_o,
  output logic [1:0]          missing_channel_o,
  output logic [DIM_W-1:0]    image_width_o,
  output logic [DIM_W-1:0]    image_height_o,
  output logic                last_pixel_o
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    room;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data = data_byte_i;
  assign in_item.eos  = end_of_stream_i;

  // Parse a held byte whenever the result register can take its result
  assign fire = held_valid & room;

  ppm_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .take_i       (fire),
    .held_valid_o (held_valid),
    .held_o       (held_item)
  );

  ppm_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ppm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & res_valid),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  // Result fields to ports
  assign result_kind_o     = out_res.kind;
  assign red_o             = out_res.red;
  assign green_o           = out_res.green;
  assign blue_o            = out_res.blue;
  assign column_o          = out_res.column;
  assign row_o             = out_res.row;
  assign missing_channel_o = out_res.missing;
  assign image_width_o     = out_res.img_w;
  assign image_height_o    = out_res.img_h;
  assign last_pixel_o      = out_res.last;

endmodule

// ----- sv/ppm_checker.sv -----
// Port-level checks for the P6 stream parser, bound to the top level.
// Watches the top-level ports only; uses ppm_pkg.
module ppm_checker
  import ppm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          result_kind_o,
  input logic [7:0]          red_o,
  input logic [7:0]          green_o,
  input logic [7:0]          blue_o,
  input logic [COORD_W-1:0]  column_o,
  input logic [COORD_W-1:0]  row_o,
  input logic [1:0]          missing_channel_o,
  input logic [DIM_W-1:0]    image_width_o,
  input logic [DIM_W-1:0]    image_height_o,
  input logic                last_pixel_o
);

  logic out_take;
  logic is_error;

  assign out_take = out_valid_o & ~out_stall_i;
  assign is_error = (result_kind_o == KIND_BAD_MAGIC) || (result_kind_o == KIND_BAD_DIM) ||
                    (result_kind_o == KIND_BAD_MAXVAL) || (result_kind_o == KIND_TRUNC);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
                                   $stable(red_o) && $stable(green_o) && $stable(blue_o) &&
                                   $stable(column_o) && $stable(row_o) &&
                                   $stable(missing_channel_o) && $stable(image_width_o) &&
                                   $stable(image_height_o) && $stable(last_pixel_o))
    else $error("stalled result changed");

  // An empty result register never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // Nothing follows an error or the final result
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && (is_error || last_pixel_o) |=> !out_valid_o)
    else $error("result after halt");

  // Empty image is the only header that ends the stream
  a_empty_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_HEADER) && last_pixel_o |->
      (image_width_o == '0) || (image_height_o == '0))
    else $error("header flagged last with nonzero size");

endmodule

bind ppm_p6_stream_parser ppm_checker u_ppm_checker (.*);
